// ----- hw/rtl/epri_pkg.sv -----
// Shared types and constants for the echo pulse range indicator.
// Holds register reset values, register indexes, the job and config structs,
// and the back-end state encoding. No dependencies.
package epri_pkg;

   localparam int TIME_W     = 16;
   localparam int REG_W      = 24;
   localparam int DIST_W     = 24;
   localparam int NUM_W      = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int PERIOD_W   = 16;
   localparam int COMPARE_W  = 15;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [8:0]  SOUND_FACTOR = 9'd343;
   localparam logic [6:0]  TONE_SCALE   = 7'd100;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;

   localparam logic [REG_W-1:0] NEAR_LIMIT_RST  = 24'd100000;
   localparam logic [REG_W-1:0] MID_LIMIT_RST   = 24'd300000;
   localparam logic [REG_W-1:0] FAR_LIMIT_RST   = 24'd500000;
   localparam logic [REG_W-1:0] TONE_LIMIT_RST  = 24'd500000;
   localparam logic [REG_W-1:0] TONE_BASE_RST   = 24'd500000;
   localparam logic [REG_W-1:0] TONE_CLOCK_RST  = 24'd1048576;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEAR_LIMIT = 3'd0,
      CSR_MID_LIMIT  = 3'd1,
      CSR_FAR_LIMIT  = 3'd2,
      CSR_TONE_LIMIT = 3'd3,
      CSR_TONE_BASE  = 3'd4,
      CSR_TONE_CLOCK = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ZONE_NEAR   = 2'd0,
      ZONE_CLOSE  = 2'd1,
      ZONE_MIDDLE = 2'd2,
      ZONE_FAR    = 2'd3
   } zone_type;

   typedef struct packed {
      logic [REG_W-1:0] near_limit;
      logic [REG_W-1:0] mid_limit;
      logic [REG_W-1:0] far_limit;
      logic [REG_W-1:0] tone_limit;
      logic [REG_W-1:0] tone_base_x100;
      logic [REG_W-1:0] tone_clock_hz;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] width;
   } job_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_CLASS = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } back_state_type;

endpackage

// ----- hw/rtl/epri_front.sv -----
// Front end: accepts echo capture transactions, keeps the rising-edge time,
// and turns each falling edge into a pulse-width job. Depends on epri_pkg.
module epri_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_edge_rising,
   input  logic [epri_pkg::TIME_W-1:0]   req_capture_time,
   input  logic                          queue_full,
   output logic                          push,
   output epri_pkg::job_type             job
);
   import epri_pkg::*;

   logic [TIME_W-1:0] rise_time_ff;
   logic [TIME_W-1:0] rise_time_in;
   logic              accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && !req_edge_rising;
   assign job.width = req_capture_time - rise_time_ff;

   always_comb begin
      rise_time_in = rise_time_ff;
      if (accept && req_edge_rising) begin
         rise_time_in = req_capture_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_time_ff <= '0;
      end else begin
         rise_time_ff <= rise_time_in;
      end
   end

endmodule

// ----- hw/rtl/epri_queue.sv -----
// Small job queue between the front end and the back end.
// Register-based FIFO of job_type entries. Depends on epri_pkg.
module epri_queue #(
   parameter int DEPTH = epri_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  epri_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output epri_pkg::job_type head_job
);
   import epri_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head_job  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/epri_back.sv -----
// Back end: converts a pulse width to distance, zone, lights and tone timing,
// using a radix-2 restoring divider, and holds the result register.
// Depends on epri_pkg.
module epri_back (
   input  logic                              clock,
   input  logic                              reset,
   input  epri_pkg::cfg_type                 cfg,
   input  logic                              job_valid,
   input  epri_pkg::job_type                 job,
   output logic                              job_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [epri_pkg::DIST_W-1:0]       rsp_distance_raw,
   output logic [1:0]                        rsp_zone,
   output logic                              rsp_light_red,
   output logic                              rsp_light_green,
   output logic [epri_pkg::PERIOD_W-1:0]     rsp_tone_period,
   output logic [epri_pkg::COMPARE_W-1:0]    rsp_tone_compare
);
   import epri_pkg::*;

   back_state_type       state_ff, state_in;
   logic [TIME_W-1:0]    width_ff, width_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   zone_type             zone_ff, zone_in;
   logic [REG_W-1:0]     div_ff, div_in;
   logic [REG_W-1:0]     rem_ff, rem_in;
   logic [PERIOD_W-1:0]  num_lo_ff, num_lo_in;
   logic [PERIOD_W-1:0]  quot_ff, quot_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic [DIST_W-1:0]    out_dist_ff, out_dist_in;
   zone_type             out_zone_ff, out_zone_in;
   logic [PERIOD_W-1:0]  out_period_ff, out_period_in;

   logic [DIST_W:0]      dist_prod;
   logic [REG_W-1:0]     div_now;
   logic [REG_W:0]       rem_shift;
   logic                 rem_ge;
   logic                 tone_on;
   logic                 tone_sat;
   logic                 quot_ovf;
   logic                 out_free;

   assign dist_prod = (DIST_W + 1)'(width_ff) * (DIST_W + 1)'(SOUND_FACTOR);
   assign div_now   = cfg.tone_base_x100 - dist_ff;
   assign tone_on   = (dist_ff <= cfg.tone_limit);
   assign tone_sat  = (cfg.tone_base_x100 <= dist_ff);
   assign quot_ovf  = (REG_W'(num_ff[NUM_W-1:PERIOD_W]) >= div_now);
   assign rem_shift = {rem_ff, num_lo_ff[PERIOD_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign job_pop   = (state_ff == ST_IDLE) && job_valid;

   always_comb begin
      state_in      = state_ff;
      width_in      = width_ff;
      dist_in       = dist_ff;
      num_in        = num_ff;
      zone_in       = zone_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      num_lo_in     = num_lo_ff;
      quot_in       = quot_ff;
      cnt_in        = cnt_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_dist_in   = out_dist_ff;
      out_zone_in   = out_zone_ff;
      out_period_in = out_period_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               width_in = job.width;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            dist_in  = dist_prod[DIST_W:1];
            num_in   = NUM_W'(cfg.tone_clock_hz) * NUM_W'(TONE_SCALE);
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            if (dist_ff < cfg.near_limit) begin
               zone_in = ZONE_NEAR;
            end else if (dist_ff < cfg.mid_limit) begin
               zone_in = ZONE_CLOSE;
            end else if (dist_ff < cfg.far_limit) begin
               zone_in = ZONE_MIDDLE;
            end else begin
               zone_in = ZONE_FAR;
            end
            div_in    = div_now;
            rem_in    = REG_W'(num_ff[NUM_W-1:PERIOD_W]);
            num_lo_in = num_ff[PERIOD_W-1:0];
            cnt_in    = '1;
            if (!tone_on) begin
               quot_in  = '0;
               state_in = ST_DONE;
            end else if (tone_sat || quot_ovf) begin
               quot_in  = PERIOD_MAX;
               state_in = ST_DONE;
            end else begin
               quot_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in    = rem_ge ? REG_W'(rem_shift - {1'b0, div_ff}) : rem_shift[REG_W-1:0];
            quot_in   = {quot_ff[PERIOD_W-2:0], rem_ge};
            num_lo_in = {num_lo_ff[PERIOD_W-2:0], 1'b0};
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_dist_in   = dist_ff;
               out_zone_in   = zone_ff;
               out_period_in = quot_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff      <= width_in;
      dist_ff       <= dist_in;
      num_ff        <= num_in;
      zone_ff       <= zone_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      num_lo_ff     <= num_lo_in;
      quot_ff       <= quot_in;
      cnt_ff        <= cnt_in;
      out_dist_ff   <= out_dist_in;
      out_zone_ff   <= out_zone_in;
      out_period_ff <= out_period_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_distance_raw = out_dist_ff;
   assign rsp_zone         = out_zone_ff;
   assign rsp_light_red    = (out_zone_ff == ZONE_NEAR) || (out_zone_ff == ZONE_CLOSE);
   assign rsp_light_green  = (out_zone_ff == ZONE_NEAR) || (out_zone_ff == ZONE_MIDDLE);
   assign rsp_tone_period  = out_period_ff;
   assign rsp_tone_compare = out_period_ff[PERIOD_W-1:1];

endmodule

// ----- hw/rtl/echo_pulse_range_indicator_top.sv -----
// Top level of the echo pulse range indicator: configuration registers,
// front end, job queue and back end. Depends on epri_pkg, epri_front,
// epri_queue and epri_back.
//
// The request channel carries echo capture transactions: an edge direction
// and the 16-bit timer value captured at that edge. A rising edge only
// stores its time and produces no response. A falling edge produces one
// response transaction with the distance, zone, indicator lights and the
// tone timer period and compare values.
// The front end accepts a transaction whenever req_stall is low and queues
// falling-edge jobs; req_stall rises only while the job queue is full. The
// back end takes a new job only from ST_IDLE and runs it through ST_MUL,
// ST_CLASS and ST_DONE when the tone is off or saturated, adding ST_DIV when
// the 16-step radix-2 divider runs; that divider limits the job rate.
// The response sits in an output register; while rsp_stall is high it holds,
// and the back end and queue keep working until they back up.
// Reset clears the stored rising-edge time to zero, empties the queue and
// restores every configuration register to its default value.
// Configuration registers are written with csr_write; write only when idle.
module echo_pulse_range_indicator_top #(
   parameter int QUEUE_DEPTH = epri_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_edge_rising,
   input  logic [epri_pkg::TIME_W-1:0]       req_capture_time,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [epri_pkg::DIST_W-1:0]       rsp_distance_raw,
   output logic [1:0]                        rsp_zone,
   output logic                              rsp_light_red,
   output logic                              rsp_light_green,
   output logic [epri_pkg::PERIOD_W-1:0]     rsp_tone_period,
   output logic [epri_pkg::COMPARE_W-1:0]    rsp_tone_compare,
   input  logic                              csr_write,
   input  logic [epri_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [epri_pkg::REG_W-1:0]        csr_wdata
);
   import epri_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_not_empty;
   job_type  push_job;
   job_type  head_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_NEAR_LIMIT: cfg_in.near_limit     = csr_wdata;
            CSR_MID_LIMIT:  cfg_in.mid_limit      = csr_wdata;
            CSR_FAR_LIMIT:  cfg_in.far_limit      = csr_wdata;
            CSR_TONE_LIMIT: cfg_in.tone_limit     = csr_wdata;
            CSR_TONE_BASE:  cfg_in.tone_base_x100 = csr_wdata;
            CSR_TONE_CLOCK: cfg_in.tone_clock_hz  = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_limit     <= NEAR_LIMIT_RST;
         cfg_ff.mid_limit      <= MID_LIMIT_RST;
         cfg_ff.far_limit      <= FAR_LIMIT_RST;
         cfg_ff.tone_limit     <= TONE_LIMIT_RST;
         cfg_ff.tone_base_x100 <= TONE_BASE_RST;
         cfg_ff.tone_clock_hz  <= TONE_CLOCK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   epri_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_edge_rising  (req_edge_rising),
      .req_capture_time (req_capture_time),
      .queue_full       (q_full),
      .push             (q_push),
      .job              (push_job)
   );

   epri_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   epri_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .job_valid        (q_not_empty),
      .job              (head_job),
      .job_pop          (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_distance_raw (rsp_distance_raw),
      .rsp_zone         (rsp_zone),
      .rsp_light_red    (rsp_light_red),
      .rsp_light_green  (rsp_light_green),
      .rsp_tone_period  (rsp_tone_period),
      .rsp_tone_compare (rsp_tone_compare)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("job pushed into a full queue");

   a_single_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !q_pop)
      else $error("back end took two jobs in consecutive cycles");

   a_lights_match_zone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_light_red == (rsp_zone == ZONE_NEAR || rsp_zone == ZONE_CLOSE))
                 && (rsp_light_green == (rsp_zone == ZONE_NEAR || rsp_zone == ZONE_MIDDLE)))
      else $error("indicator lights disagree with zone");
`endif

endmodule
